### hdl/fgrd_pkg.sv
// font glyph row decoder: shared constants, codes and the command type
// used by the front end, the command queue and the row emitter
// no dependencies
package fgrd_pkg;

  // geometry and table size
  localparam int TABLE_DEPTH   = 128;
  localparam int GLYPH_ROWS    = 16;
  localparam int GLYPH_COLUMNS = 8;
  localparam int TBL_AW        = $clog2(TABLE_DEPTH);
  localparam int QUEUE_DEPTH   = 2;

  // field types
  typedef logic [1:0]               op_t;
  typedef logic [1:0]               mode_t;
  typedef logic [6:0]               tidx_t;
  typedef logic [7:0]               byte_t;
  typedef logic [3:0]               row_t;
  typedef logic [4:0]               row_cnt_t;
  typedef logic [GLYPH_COLUMNS-1:0] pix_t;

  // item opcodes
  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_HEADER = 2'd1;
  localparam op_t OP_DATA   = 2'd2;

  // compression modes
  localparam mode_t MODE_RAW    = 2'd0;
  localparam mode_t MODE_TABLE  = 2'd1;
  localparam mode_t MODE_PREFIX = 2'd2;

  // row constants
  localparam row_cnt_t ROWS_ALL   = row_cnt_t'(GLYPH_ROWS);
  localparam row_t     ROW_LAST   = row_t'(GLYPH_ROWS - 1);
  localparam byte_t    PREFIX_MIN = 8'hF0;

  // one run of rows for the emitter: rows from first_row up to data_end-1
  // carry pixels, then blank rows to the bottom when tail is set
  typedef struct packed {
    row_t     first_row;
    row_cnt_t data_end;
    pix_t     pixels;
    logic     tail;
  } cmd_t;

endpackage

### hdl/fgrd_if.sv
// font glyph row decoder: valid/ready channel interfaces for input beats
// and row result beats
// depends on fgrd_pkg
interface fgrd_in_if;
  import fgrd_pkg::*;

  logic  valid;
  logic  ready;
  op_t   op;
  tidx_t table_index;
  byte_t byte_value;

  modport source (output valid, output op, output table_index, output byte_value,
                  input ready);
  modport sink   (input valid, input op, input table_index, input byte_value,
                  output ready);
endinterface

interface fgrd_out_if;
  import fgrd_pkg::*;

  logic valid;
  logic ready;
  row_t row_number;
  pix_t row_pixels;
  logic glyph_done;

  modport source (output valid, output row_number, output row_pixels, output glyph_done,
                  input ready);
  modport sink   (input valid, input row_number, input row_pixels, input glyph_done,
                  output ready);
endinterface

### hdl/fgrd_front.sv
// font glyph row decoder front end: accepts input beats, holds the row table,
// mode register and glyph state, and turns beats with rows into row commands
// depends on fgrd_pkg and fgrd_if
module fgrd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  fgrd_in_if.sink              in_ch,
  input  logic                 cfg_we,
  input  fgrd_pkg::mode_t      cfg_wdata,
  output logic                 push_valid,
  input  logic                 push_ready,
  output fgrd_pkg::cmd_t       push_cmd
);
  import fgrd_pkg::*;

  // glyph state
  mode_t    mode_r;
  row_cnt_t next_row_r, next_row_nxt;
  row_cnt_t end_row_r, end_row_nxt;
  logic     active_r, active_nxt;
  row_cnt_t pend_r, pend_nxt;

  // stage between accept and push, waits for the table read
  logic     s1_valid_r;
  cmd_t     s1_cmd_r;
  logic     s1_tbl_r;
  pix_t     tbl_rd_r;
  logic     tbl_hit_r;

  logic     accept;
  logic     push_nxt;
  cmd_t     cmd_nxt;
  logic     tbl_nxt;

  // table memory
  pix_t     tbl_mem [TABLE_DEPTH];

  assign in_ch.ready = !s1_valid_r || push_ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // classify the beat and work out the next glyph state
  always_comb begin
    logic [3:0] top;
    row_cnt_t   size;
    row_cnt_t   rep;
    logic [5:0] sum;
    row_cnt_t   dend;
    logic       take;
    next_row_nxt = next_row_r;
    end_row_nxt  = end_row_r;
    active_nxt   = active_r;
    pend_nxt     = pend_r;
    push_nxt     = 1'b0;
    cmd_nxt      = '0;
    tbl_nxt      = 1'b0;
    top          = in_ch.byte_value[7:4];
    size         = ROWS_ALL - {1'b0, in_ch.byte_value[3:0]};
    rep          = '0;
    sum          = '0;
    dend         = '0;
    take         = 1'b0;
    unique case (in_ch.op)
      OP_HEADER: begin
        pend_nxt    = '0;
        end_row_nxt = size;
        if ({1'b0, top} >= size) begin
          // all-blank glyph: sixteen blank rows, done on the last
          push_nxt          = 1'b1;
          cmd_nxt.tail      = 1'b1;
          active_nxt        = 1'b0;
          next_row_nxt      = ROWS_ALL;
        end else begin
          push_nxt          = (top != 4'd0);
          cmd_nxt.data_end  = {1'b0, top};
          active_nxt        = 1'b1;
          next_row_nxt      = {1'b0, top};
        end
      end
      OP_DATA: begin
        if (active_r) begin
          take = 1'b1;
          unique case (mode_r)
            MODE_RAW: begin
              rep = 5'd1;
            end
            MODE_TABLE: begin
              rep     = in_ch.byte_value[7] ? 5'd2 : 5'd1;
              tbl_nxt = 1'b1;
            end
            default: begin
              tbl_nxt = 1'b1;
              if (pend_r != '0) begin
                rep      = pend_r;
                pend_nxt = '0;
              end else if (in_ch.byte_value > PREFIX_MIN) begin
                // repeat prefix, no rows
                pend_nxt = {1'b0, in_ch.byte_value[3:0]} + 5'd1;
                take     = 1'b0;
              end else begin
                rep = in_ch.byte_value[7] ? 5'd2 : 5'd1;
              end
            end
          endcase
          if (take) begin
            sum  = {1'b0, next_row_r} + {1'b0, rep};
            dend = (sum > {1'b0, ROWS_ALL}) ? ROWS_ALL : sum[4:0];
            push_nxt         = 1'b1;
            cmd_nxt.first_row = next_row_r[3:0];
            cmd_nxt.data_end = dend;
            cmd_nxt.pixels   = in_ch.byte_value;
            cmd_nxt.tail     = (dend >= end_row_r);
            next_row_nxt     = dend;
            if (dend >= end_row_r) begin
              active_nxt = 1'b0;
              pend_nxt   = '0;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_PREFIX;
      next_row_r <= '0;
      end_row_r  <= '0;
      active_r   <= 1'b0;
      pend_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (accept) begin
        next_row_r <= next_row_nxt;
        end_row_r  <= end_row_nxt;
        active_r   <= active_nxt;
        pend_r     <= pend_nxt;
        s1_valid_r <= push_nxt;
      end else if (push_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= cmd_nxt;
      s1_tbl_r <= tbl_nxt;
    end
  end

  // row table write and registered lookup
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.op == OP_LOAD && int'(in_ch.table_index) < TABLE_DEPTH) begin
        tbl_mem[in_ch.table_index[TBL_AW-1:0]] <= in_ch.byte_value;
      end
      tbl_rd_r  <= tbl_mem[in_ch.byte_value[TBL_AW-1:0]];
      tbl_hit_r <= (int'(in_ch.byte_value[6:0]) < TABLE_DEPTH);
    end
  end

  // command toward the queue
  always_comb begin
    push_cmd = s1_cmd_r;
    if (s1_tbl_r) begin
      push_cmd.pixels = tbl_hit_r ? tbl_rd_r : '0;
    end
  end
  assign push_valid = s1_valid_r;

endmodule

### hdl/fgrd_queue.sv
// font glyph row decoder command queue: short fifo between front end and
// row emitter so that each side stalls on its own
// depends on fgrd_pkg
module fgrd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fgrd_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fgrd_pkg::cmd_t pop_cmd
);
  import fgrd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            q_mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = q_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/fgrd_back.sv
// font glyph row decoder row emitter: walks each row command one row per
// cycle, while the result channel is not stalled, into the registered result channel
// depends on fgrd_pkg and fgrd_if
module fgrd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  fgrd_pkg::cmd_t pop_cmd,
  fgrd_out_if.source     out_ch
);
  import fgrd_pkg::*;

  logic busy_r;
  cmd_t cur_r;
  row_t row_r;
  logic out_valid_r;
  row_t out_row_r;
  pix_t out_pix_r;
  logic out_done_r;
  logic emit;
  logic last;

  assign emit = busy_r && (!out_valid_r || out_ch.ready);
  assign last = cur_r.tail ? (row_r == ROW_LAST)
                           : (({1'b0, row_r} + 5'd1) >= cur_r.data_end);
  assign pop_ready = !busy_r || (emit && last);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.row_number = out_row_r;
  assign out_ch.row_pixels = out_pix_r;
  assign out_ch.glyph_done = out_done_r;

  // run walker and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (pop_valid && pop_ready) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  // run and result payload
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_r <= pop_cmd;
      row_r <= pop_cmd.first_row;
    end else if (emit) begin
      row_r <= row_r + 4'd1;
    end
    if (emit) begin
      out_row_r  <= row_r;
      out_pix_r  <= ({1'b0, row_r} < cur_r.data_end) ? cur_r.pixels : '0;
      out_done_r <= cur_r.tail && (row_r == ROW_LAST);
    end
  end

`ifndef NO_ASSERTIONS
  // a done beat is always the bottom row
  a_done_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_row_r == ROW_LAST)
    else $error("glyph_done on a row other than the bottom");

  // a run without tail never walks past its data rows
  a_row_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !cur_r.tail |-> {1'b0, row_r} < cur_r.data_end)
    else $error("row walker past end of data rows");

  // a stalled result freezes the walker
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && out_valid_r && !out_ch.ready |=> busy_r && $stable(row_r))
    else $error("row walker moved during output stall");
`endif

endmodule

### hdl/font_glyph_row_decoder.sv
// font glyph row decoder top level: front end, command queue, row emitter
// depends on fgrd_pkg, fgrd_if, fgrd_front, fgrd_queue, fgrd_back
//
//   channel   dir   handshake     payload
//   in_ch     in    valid/ready   op, table_index, byte_value
//   out_ch    out   valid/ready   row_number, row_pixels, glyph_done
//   cfg       in    cfg_we        cfg_wdata (compression mode)
//
// an input beat is taken into the front-end stage together with the registered
// row table read, then its command passes through the queue and the emitter's
// run register into the registered out_ch beat; the emitter walks a beat's rows
// one by one, and a beat without rows sends no command to the queue; reset is
// synchronous active low, clears glyph state, queue and emitter and sets the
// mode to repeat prefix; in_ch stalls while a command waits on a full queue
module font_glyph_row_decoder (
  input  logic            clk,
  input  logic            rst_n,
  fgrd_in_if.sink         in_ch,
  fgrd_out_if.source      out_ch,
  input  logic            cfg_we,
  input  fgrd_pkg::mode_t cfg_wdata
);
  import fgrd_pkg::*;

  logic q_push_valid;
  logic q_push_ready;
  cmd_t q_push_cmd;
  logic q_pop_valid;
  logic q_pop_ready;
  cmd_t q_pop_cmd;

  // accept and classify
  fgrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd)
  );

  // command queue
  fgrd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  // row emitter
  fgrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_ready (q_pop_ready),
    .pop_cmd   (q_pop_cmd),
    .out_ch    (out_ch)
  );

endmodule
